>>> design/shacr_pkg.sv
package shacr_pkg;

   localparam int unsigned WORDS       = 8;
   localparam int unsigned ROUNDS      = 80;
   localparam int unsigned ROUND_WIDTH = $clog2(ROUNDS);
   localparam int unsigned INDEX_WIDTH = $clog2(WORDS);

   localparam logic [ROUND_WIDTH-1:0] LAST_ROUND = ROUND_WIDTH'(ROUNDS - 1);
   localparam logic [INDEX_WIDTH-1:0] LAST_INDEX = INDEX_WIDTH'(WORDS - 1);

   // Word 0 is the working word a (most significant chain word).
   typedef logic [0:WORDS-1][63:0] word_array_type;

   localparam word_array_type INIT_HASH = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   localparam logic [63:0] ROUND_K [0:ROUNDS-1] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   // One registered round input: schedule word already summed with its round constant.
   typedef struct packed {
      logic [63:0]            wk;
      logic                   restart;
      logic [ROUND_WIDTH-1:0] round;
   } round_item_type;

   typedef struct packed {
      logic           valid;
      word_array_type words;
   } digest_load_type;

   function automatic logic [63:0] big_sigma0(input logic [63:0] x);
      return {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
   endfunction

   function automatic logic [63:0] big_sigma1(input logic [63:0] x);
      return {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
   endfunction

   function automatic logic [63:0] choose(input logic [63:0] e, input logic [63:0] f,
                                          input logic [63:0] g);
      return (e & f) ^ (~e & g);
   endfunction

   function automatic logic [63:0] majority(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] c);
      return (a & b) ^ (a & c) ^ (b & c);
   endfunction

endpackage

>>> design/sha512_compression_rounds_top.sv
// Output order: the first digest word of a block is offered once that block's 80th schedule word
// has passed the input register and its final round has loaded the digest buffer; the eight digest
// words follow at one per cycle while rsp_tready is high.
// Throughput: one schedule word per cycle; the final round of a block waits only while
// the eight words of the previous digest are still in the output buffer.
// Reset: synchronous; clears the round counter and the valid flags, and loads the chain
// with the SHA-512 initial hash value.
module sha512_compression_rounds_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,    // [63:0] schedule_word
   input  logic [0:0]   req_tuser,    // [0] restart_chain
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,    // [2:0] digest_index, [66:3] digest_word
   output logic         rsp_tlast     // last_word
);

   logic                         item_valid;
   shacr_pkg::round_item_type    item;
   logic                         core_ready;
   logic                         digest_busy;
   shacr_pkg::digest_load_type   digest_load;

   shacr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .core_ready (core_ready),
      .item_valid (item_valid),
      .item       (item)
   );

   shacr_round_core u_round_core (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item        (item),
      .digest_busy (digest_busy),
      .core_ready  (core_ready),
      .digest_load (digest_load)
   );

   shacr_digest_buf u_digest_buf (
      .clock       (clock),
      .reset       (reset),
      .digest_load (digest_load),
      .digest_busy (digest_busy),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   // A new digest must never overwrite one that is still being sent.
   assert property (@(posedge clock) disable iff (reset)
      digest_load.valid |-> !rsp_tvalid)
      else $error("digest loaded while previous digest still pending");

   // In the cycle after the last word's transfer the buffer is empty.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid)
      else $error("output still valid after last digest word");

   // The round tag carried with each item stays inside the 80 rounds.
   assert property (@(posedge clock) disable iff (reset)
      item_valid |-> (item.round <= shacr_pkg::LAST_ROUND))
      else $error("round index out of range");

endmodule

>>> design/shacr_in_stage.sv
module shacr_in_stage (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [63:0]                      req_tdata,   // [63:0] schedule_word
   input  logic [0:0]                       req_tuser,   // [0] restart_chain
   input  logic                             core_ready,
   output logic                             item_valid,
   output shacr_pkg::round_item_type        item
);

   logic                                    valid_ff, valid_in;
   logic [shacr_pkg::ROUND_WIDTH-1:0]       round_ff, round_in;
   shacr_pkg::round_item_type               item_ff, item_in;
   logic                                    accept;

   assign req_tready = !valid_ff || core_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff && !core_ready;
      round_in = round_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in        = 1'b1;
         item_in.wk      = req_tdata + shacr_pkg::ROUND_K[round_ff];
         item_in.restart = req_tuser[0];
         item_in.round   = round_ff;
         if (round_ff == shacr_pkg::LAST_ROUND) begin
            round_in = '0;
         end else begin
            round_in = round_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         round_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         round_ff <= round_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> design/shacr_round_core.sv
module shacr_round_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              item_valid,
   input  shacr_pkg::round_item_type         item,
   input  logic                              digest_busy,
   output logic                              core_ready,
   output shacr_pkg::digest_load_type        digest_load
);

   shacr_pkg::word_array_type working_ff, working_in;
   shacr_pkg::word_array_type chain_ff, chain_in;
   shacr_pkg::word_array_type src;
   shacr_pkg::word_array_type next_work;
   shacr_pkg::word_array_type sums;
   logic [63:0]               t1, t2;
   logic                      consume;
   logic                      is_first, is_last;

   assign is_first = (item.round == '0);
   assign is_last  = (item.round == shacr_pkg::LAST_ROUND);

   // The final round needs the digest buffer free before it may fold into the chain.
   assign core_ready = !(item_valid && is_last && digest_busy);
   assign consume    = item_valid && core_ready;

   always_comb begin
      if (is_first) begin
         src = item.restart ? shacr_pkg::INIT_HASH : chain_ff;
      end else begin
         src = working_ff;
      end
      t1 = src[7] + shacr_pkg::big_sigma1(src[4]) + shacr_pkg::choose(src[4], src[5], src[6])
           + item.wk;
      t2 = shacr_pkg::big_sigma0(src[0]) + shacr_pkg::majority(src[0], src[1], src[2]);
      next_work[0] = t1 + t2;
      next_work[1] = src[0];
      next_work[2] = src[1];
      next_work[3] = src[2];
      next_work[4] = src[3] + t1;
      next_work[5] = src[4];
      next_work[6] = src[5];
      next_work[7] = src[6];
      for (int i = 0; i < shacr_pkg::WORDS; i++) begin
         sums[i] = chain_ff[i] + next_work[i];
      end
   end

   always_comb begin
      working_in = working_ff;
      chain_in   = chain_ff;
      if (consume) begin
         working_in = next_work;
         if (is_first && item.restart) begin
            chain_in = shacr_pkg::INIT_HASH;
         end
         if (is_last) begin
            chain_in = sums;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= shacr_pkg::INIT_HASH;
      end else begin
         chain_ff <= chain_in;
      end
      working_ff <= working_in;
   end

   assign digest_load.valid = consume && is_last;
   assign digest_load.words = sums;

endmodule

>>> design/shacr_digest_buf.sv
module shacr_digest_buf (
   input  logic                              clock,
   input  logic                              reset,
   input  shacr_pkg::digest_load_type        digest_load,
   output logic                              digest_busy,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [71:0]                       rsp_tdata,   // [2:0] digest_index, [66:3] digest_word
   output logic                              rsp_tlast    // last_word
);

   shacr_pkg::word_array_type           digest_ff, digest_in;
   logic                                busy_ff, busy_in;
   logic [shacr_pkg::INDEX_WIDTH-1:0]   index_ff, index_in;
   logic                                transfer;

   assign transfer = busy_ff && rsp_tready;

   always_comb begin
      digest_in = digest_ff;
      busy_in   = busy_ff;
      index_in  = index_ff;
      if (digest_load.valid) begin
         digest_in = digest_load.words;
         busy_in   = 1'b1;
         index_in  = '0;
      end else if (transfer) begin
         index_in = index_ff + 1'b1;
         if (index_ff == shacr_pkg::LAST_INDEX) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         index_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         index_ff <= index_in;
      end
      digest_ff <= digest_in;
   end

   assign digest_busy = busy_ff;
   assign rsp_tvalid  = busy_ff;
   assign rsp_tdata   = {5'b0, digest_ff[index_ff], index_ff};
   assign rsp_tlast   = (index_ff == shacr_pkg::LAST_INDEX);

endmodule
